[rtl/iat_pkg.sv]
// ----------------------------------------------------------------------------
// iat_pkg: shared types and constants of the instance affine transform
// Fixed-point constants, CORDIC arctangent table, vertex table and the
// words that travel down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package iat_pkg;

   localparam int unsigned TWO_PI  = 411775;
   localparam int unsigned PI      = 205887;
   localparam int unsigned HALF_PI = 102944;
   localparam int unsigned GAIN    = 652032874;
   // 2^31 mod 2*pi, removes the offset of the biased angle
   localparam int unsigned ANG_OFF = int'(64'd2147483648 % 64'(TWO_PI));
   localparam logic [31:0] ANG_RECIP = 32'((64'd1 << 50) / 64'(TWO_PI));
   localparam logic [24:0] ALPHA_RECIP = 25'((64'd1 << 32) / 64'd255);
   localparam int unsigned ATAN_ENTRIES = 24;

   typedef enum logic [2:0] {
      CSR_PARENT_A    = 3'd0,
      CSR_PARENT_B    = 3'd1,
      CSR_PARENT_C    = 3'd2,
      CSR_PARENT_D    = 3'd3,
      CSR_PARENT_TX   = 3'd4,
      CSR_PARENT_TY   = 3'd5,
      CSR_GROUP_ALPHA = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] half_w;
      logic signed [31:0] half_h;
      logic [2:0]         shape;
      logic [47:0]        color;
      logic [15:0]        alpha;
   } side_type;

   typedef struct packed {
      logic               valid;
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      side_type           side;
   } cord_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic [3:0] vertex_count(input logic [2:0] shape);
      logic [3:0] v;
      case (shape)
         3'd0: v = 4'd5;
         3'd1: v = 4'd10;
         3'd2: v = 4'd7;
         3'd3: v = 4'd6;
         3'd4: v = 4'd8;
         3'd5: v = 4'd6;
         3'd6: v = 4'd3;
         default: v = 4'd12;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/instance_affine_transform.sv]
// A req word passes the front end, the CORDIC cells and the matrix back end.
// Throughput: one word per cycle; the pipeline advances whenever the output
// register is empty or taken, so rsp_tready low with rsp_tvalid high stalls
// every stage. Inactive words are dropped at the input and give no rsp word.
// Reset (synchronous, active high) clears all valid bits and loads the
// parent matrix with identity and group alpha with 255.
// ----------------------------------------------------------------------------
// instance_affine_transform: per-instance world matrix builder
// CORDIC rotation chain between a reduction front end and a matrix back end.
// ----------------------------------------------------------------------------
`default_nettype none
module instance_affine_transform #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // pos_x, pos_y, width, height, angle, shape_id, red, green, blue, alpha_in
   input  wire logic [231:0]  req_tdata,
   // active
   input  wire logic          req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // world_m00, world_m10, world_m01, world_m11, world_tx, world_ty, cos_out,
   // sin_out, shape_out, vertex_count, color_rgb, alpha_out, one zero pad bit
   output logic [295:0]       rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   logic en;
   logic signed [31:0] pa_ff, pb_ff, pc_ff, pd_ff, ptx_ff, pty_ff;
   logic [7:0] ga_ff;
   iat_pkg::cord_type chain [CORDIC_STAGES + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff  <= 32'sd65536;
         pb_ff  <= '0;
         pc_ff  <= '0;
         pd_ff  <= 32'sd65536;
         ptx_ff <= '0;
         pty_ff <= '0;
         ga_ff  <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_index)
            iat_pkg::CSR_PARENT_A:    pa_ff  <= csr_wdata;
            iat_pkg::CSR_PARENT_B:    pb_ff  <= csr_wdata;
            iat_pkg::CSR_PARENT_C:    pc_ff  <= csr_wdata;
            iat_pkg::CSR_PARENT_D:    pd_ff  <= csr_wdata;
            iat_pkg::CSR_PARENT_TX:   ptx_ff <= csr_wdata;
            iat_pkg::CSR_PARENT_TY:   pty_ff <= csr_wdata;
            iat_pkg::CSR_GROUP_ALPHA: ga_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // advance when the output word is empty or taken
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   iat_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid && req_tuser),
      .pos_x       (req_tdata[31:0]),
      .pos_y       (req_tdata[63:32]),
      .width       (req_tdata[95:64]),
      .height      (req_tdata[127:96]),
      .angle       (req_tdata[159:128]),
      .shape_id    (req_tdata[167:160]),
      .color       ({req_tdata[183:168], req_tdata[199:184], req_tdata[215:200]}),
      .alpha_in    (req_tdata[231:216]),
      .group_alpha (ga_ff),
      .cord_out    (chain[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      iat_cordic_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (chain[i]),
         .q     (chain[i + 1])
      );
   end

   iat_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .d         (chain[CORDIC_STAGES]),
      .pa        (pa_ff),
      .pb        (pb_ff),
      .pc        (pc_ff),
      .pd        (pd_ff),
      .ptx       (ptx_ff),
      .pty       (pty_ff),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

[rtl/iat_front.sv]
// ----------------------------------------------------------------------------
// iat_front: angle reduction and alpha scaling
// Four stages: reduce the angle modulo 2*pi by reciprocal multiply, fold it
// into [-pi/2, pi/2] and scale alpha by group alpha / 255.
// ----------------------------------------------------------------------------
`default_nettype none
module iat_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic signed [31:0]  pos_x,
   input  wire logic signed [31:0]  pos_y,
   input  wire logic signed [31:0]  width,
   input  wire logic signed [31:0]  height,
   input  wire logic signed [31:0]  angle,
   input  wire logic [7:0]          shape_id,
   input  wire logic [47:0]         color,
   input  wire logic [15:0]         alpha_in,
   input  wire logic [7:0]          group_alpha,
   output iat_pkg::cord_type        cord_out
);

   logic [3:0]          v_ff, v_in;
   iat_pkg::side_type   s1_ff, s2_ff, s3_ff, s4_ff, s1_in, s4_in;
   logic [31:0]         u1_ff, u1_in;
   logic [13:0]         q1_ff, q1_in;
   logic [24:0]         ax1_ff, ax1_in, ax2_ff;
   logic [19:0]         rem2_ff, rem2_in;
   logic [16:0]         qa2_ff, qa2_in;
   logic [18:0]         r3_ff, r3_in;
   logic [15:0]         a3_ff, a3_in;
   logic                flip4_ff, flip4_in;
   logic signed [33:0]  z4_ff, z4_in;

   // stage 1: bias the angle to unsigned and estimate the quotient
   always_comb begin
      logic [63:0] qp;
      u1_in  = {~angle[31], angle[30:0]};
      qp     = 64'(u1_in) * 64'(iat_pkg::ANG_RECIP);
      q1_in  = qp[63:50];
      ax1_in = 25'(alpha_in) * 25'(group_alpha) + 25'd127;
      s1_in.pos_x  = pos_x;
      s1_in.pos_y  = pos_y;
      s1_in.half_w = width >>> 1;
      s1_in.half_h = height >>> 1;
      s1_in.shape  = shape_id[2:0];
      s1_in.color  = color;
      s1_in.alpha  = 16'd0;
   end

   // stage 2: remainder, still below twice the modulus
   always_comb begin
      logic [49:0] ap;
      rem2_in = 20'(u1_ff - 32'(q1_ff) * iat_pkg::TWO_PI);
      ap      = 50'(ax1_ff) * 50'(iat_pkg::ALPHA_RECIP);
      qa2_in  = ap[48:32];
   end

   // stage 3: final correction of both quotients, drop the bias
   always_comb begin
      logic [19:0] rem;
      logic [24:0] ar;
      rem = (rem2_ff >= 20'(iat_pkg::TWO_PI)) ? rem2_ff - 20'(iat_pkg::TWO_PI) : rem2_ff;
      if (rem >= 20'(iat_pkg::ANG_OFF)) begin
         r3_in = 19'(rem - 20'(iat_pkg::ANG_OFF));
      end else begin
         r3_in = 19'(rem + 20'(iat_pkg::TWO_PI) - 20'(iat_pkg::ANG_OFF));
      end
      ar = ax2_ff - ({8'd0, qa2_ff} << 8) + {8'd0, qa2_ff};
      a3_in = (ar >= 25'd255) ? 16'(qa2_ff + 17'd1) : qa2_ff[15:0];
   end

   // stage 4: map to (-pi, pi], fold into the CORDIC range
   always_comb begin
      logic signed [19:0] rs;
      rs = signed'({1'b0, r3_ff});
      if (rs > 20'sd205887) begin
         rs = rs - 20'sd411775;
      end
      flip4_in = 1'b0;
      if (rs > 20'sd102944) begin
         rs = rs - 20'sd205887;
         flip4_in = 1'b1;
      end else if (rs < -20'sd102944) begin
         rs = rs + 20'sd205887;
         flip4_in = 1'b1;
      end
      z4_in = {rs, 14'd0};
      s4_in = s3_ff;
      s4_in.alpha = a3_ff;
   end

   assign v_in = {v_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= s1_in;
         u1_ff    <= u1_in;
         q1_ff    <= q1_in;
         ax1_ff   <= ax1_in;
         s2_ff    <= s1_ff;
         rem2_ff  <= rem2_in;
         qa2_ff   <= qa2_in;
         ax2_ff   <= ax1_ff;
         s3_ff    <= s2_ff;
         r3_ff    <= r3_in;
         a3_ff    <= a3_in;
         s4_ff    <= s4_in;
         flip4_ff <= flip4_in;
         z4_ff    <= z4_in;
      end
   end

   always_comb begin
      cord_out.valid = v_ff[3];
      cord_out.flip  = flip4_ff;
      cord_out.x     = 34'(iat_pkg::GAIN);
      cord_out.y     = '0;
      cord_out.z     = z4_ff;
      cord_out.side  = s4_ff;
   end

endmodule
`default_nettype wire

[rtl/iat_cordic_cell.sv]
// ----------------------------------------------------------------------------
// iat_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by the arctangent of 2^-IDX toward z = 0 and hands the
// word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module iat_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire iat_pkg::cord_type  d,
   output iat_pkg::cord_type       q
);

   iat_pkg::cord_type q_ff, q_in;

   always_comb begin
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] at;
      dx = d.y >>> IDX;
      dy = d.x >>> IDX;
      at = signed'({2'b00, iat_pkg::atan_q30(5'(IDX))});
      q_in = d;
      if (!d.z[33]) begin
         q_in.x = d.x - dx;
         q_in.y = d.y + dy;
         q_in.z = d.z - at;
      end else begin
         q_in.x = d.x + dx;
         q_in.y = d.y - dy;
         q_in.z = d.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= q_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff.flip <= q_in.flip;
         q_ff.x    <= q_in.x;
         q_ff.y    <= q_in.y;
         q_ff.z    <= q_in.z;
         q_ff.side <= q_in.side;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

[rtl/iat_matrix.sv]
// ----------------------------------------------------------------------------
// iat_matrix: local and world matrix composition
// Rounds cos and sin, builds the scaled rotation, multiplies by the parent
// matrix and saturates the world entries into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module iat_matrix (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire iat_pkg::cord_type   d,
   input  wire logic signed [31:0]  pa,
   input  wire logic signed [31:0]  pb,
   input  wire logic signed [31:0]  pc,
   input  wire logic signed [31:0]  pd,
   input  wire logic signed [31:0]  ptx,
   input  wire logic signed [31:0]  pty,
   output logic                     out_valid,
   output logic [295:0]             out_data
);

   logic [3:0] v_ff, v_in;
   iat_pkg::side_type  s1_ff, s2_ff, s3_ff, s4_ff;
   logic signed [17:0] c1_ff, s1c_ff, c1_in, s1c_in;
   logic signed [15:0] c14_1_ff, s14_1_ff, c14_1_in, s14_1_in;
   logic signed [15:0] c14_2_ff, s14_2_ff, c14_3_ff, s14_3_ff, c14_4_ff, s14_4_ff;
   logic signed [33:0] l00_ff, l10_ff, l01_ff, l11_ff;
   logic signed [33:0] l00_in, l10_in, l01_in, l11_in;
   logic signed [49:0] p_ff [12];
   logic signed [49:0] p_in [12];
   logic signed [31:0] w_ff [6];
   logic signed [31:0] w_in [6];

   // stage 1: round cos and sin
   always_comb begin
      logic signed [33:0] cx;
      logic signed [33:0] sy;
      logic signed [20:0] cr;
      logic signed [20:0] sr;
      logic signed [18:0] cq;
      logic signed [18:0] sq;
      cx = d.flip ? -d.x : d.x;
      sy = d.flip ? -d.y : d.y;
      cr = 21'((35'(cx) + 35'sd8192) >>> 14);
      sr = 21'((35'(sy) + 35'sd8192) >>> 14);
      cq = 19'((35'(cx) + 35'sd32768) >>> 16);
      sq = 19'((35'(sy) + 35'sd32768) >>> 16);
      c1_in  = (cr > 21'sd65536) ? 18'sd65536 : (cr < -21'sd65536) ? -18'sd65536 : 18'(cr);
      s1c_in = (sr > 21'sd65536) ? 18'sd65536 : (sr < -21'sd65536) ? -18'sd65536 : 18'(sr);
      c14_1_in = (cq > 19'sd16384) ? 16'sd16384 : (cq < -19'sd16384) ? -16'sd16384 : 16'(cq);
      s14_1_in = (sq > 19'sd16384) ? 16'sd16384 : (sq < -19'sd16384) ? -16'sd16384 : 16'(sq);
   end

   // stage 2: local matrix, rotation scaled by half size
   always_comb begin
      logic signed [49:0] m00;
      logic signed [49:0] m10;
      logic signed [49:0] m01;
      logic signed [49:0] m11;
      logic signed [17:0] ns;
      ns  = -s1c_ff;
      m00 = s1_ff.half_w * c1_ff;
      m10 = s1_ff.half_w * s1c_ff;
      m01 = s1_ff.half_h * ns;
      m11 = s1_ff.half_h * c1_ff;
      l00_in = 34'((m00 + 50'sd32768) >>> 16);
      l10_in = 34'((m10 + 50'sd32768) >>> 16);
      l01_in = 34'((m01 + 50'sd32768) >>> 16);
      l11_in = 34'((m11 + 50'sd32768) >>> 16);
   end

   // stage 3: products with the parent matrix
   always_comb begin
      logic signed [65:0] m [12];
      logic signed [33:0] px;
      logic signed [33:0] py;
      px = 34'(s2_ff.pos_x);
      py = 34'(s2_ff.pos_y);
      m[0]  = pa * l00_ff;
      m[1]  = pb * l10_ff;
      m[2]  = pc * l00_ff;
      m[3]  = pd * l10_ff;
      m[4]  = pa * l01_ff;
      m[5]  = pb * l11_ff;
      m[6]  = pc * l01_ff;
      m[7]  = pd * l11_ff;
      m[8]  = pa * px;
      m[9]  = pb * py;
      m[10] = pc * px;
      m[11] = pd * py;
      for (int i = 0; i < 12; i++) begin
         p_in[i] = 50'((m[i] + 66'sd32768) >>> 16);
      end
   end

   // stage 4: sum and saturate
   always_comb begin
      logic signed [51:0] t [6];
      t[0] = 52'(p_ff[0]) + 52'(p_ff[1]);
      t[1] = 52'(p_ff[2]) + 52'(p_ff[3]);
      t[2] = 52'(p_ff[4]) + 52'(p_ff[5]);
      t[3] = 52'(p_ff[6]) + 52'(p_ff[7]);
      t[4] = 52'(p_ff[8]) + 52'(p_ff[9]) + 52'(ptx);
      t[5] = 52'(p_ff[10]) + 52'(p_ff[11]) + 52'(pty);
      for (int i = 0; i < 6; i++) begin
         if (t[i] > 52'sd2147483647) begin
            w_in[i] = 32'sh7FFFFFFF;
         end else if (t[i] < -52'sd2147483648) begin
            w_in[i] = 32'sh80000000;
         end else begin
            w_in[i] = 32'(t[i]);
         end
      end
   end

   assign v_in = {v_ff[2:0], d.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff    <= d.side;
         c1_ff    <= c1_in;
         s1c_ff   <= s1c_in;
         c14_1_ff <= c14_1_in;
         s14_1_ff <= s14_1_in;
         s2_ff    <= s1_ff;
         l00_ff   <= l00_in;
         l10_ff   <= l10_in;
         l01_ff   <= l01_in;
         l11_ff   <= l11_in;
         c14_2_ff <= c14_1_ff;
         s14_2_ff <= s14_1_ff;
         s3_ff    <= s2_ff;
         p_ff     <= p_in;
         c14_3_ff <= c14_2_ff;
         s14_3_ff <= s14_2_ff;
         s4_ff    <= s3_ff;
         w_ff     <= w_in;
         c14_4_ff <= c14_3_ff;
         s14_4_ff <= s14_3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = {1'b0, s4_ff.alpha, s4_ff.color,
                       iat_pkg::vertex_count(s4_ff.shape), s4_ff.shape,
                       s14_4_ff, c14_4_ff,
                       w_ff[5], w_ff[4], w_ff[3], w_ff[2], w_ff[1], w_ff[0]};

endmodule
`default_nettype wire

[test/instance_affine_transform_tb.sv]
// ----------------------------------------------------------------------------
// instance_affine_transform_tb: self-checking regression of the transform
// Streams random and directed instances, predicts each world matrix, color
// and alpha word, and compares every rsp word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module instance_affine_transform_tb;

   localparam int LATENCY = 8 + 16;
   localparam longint CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [231:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [295:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   instance_affine_transform uut (.*);

   typedef struct packed {
      logic active;
      logic [15:0] alpha_in;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
      logic [7:0] shape_id;
      logic [31:0] angle;
      logic [31:0] height;
      logic [31:0] width;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } inst_type;

   typedef struct packed {
      logic pad;
      logic [15:0] alpha_out;
      logic [47:0] color_rgb;
      logic [3:0] vcount;
      logic [2:0] shape_out;
      logic [15:0] sin_out;
      logic [15:0] cos_out;
      logic [31:0] ty;
      logic [31:0] tx;
      logic [31:0] m11;
      logic [31:0] m01;
      logic [31:0] m10;
      logic [31:0] m00;
   } xform_type;

   inst_type pending_insts[$];
   xform_type expected_xforms[$];
   longint par_a, par_b, par_c, par_d, par_tx, par_ty, grp_alpha;
   int errors = 0;
   longint cycles = 0;
   int hold_off = 0;
   bit stall_burst = 0;

   const longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
      524288, 262144, 131072, 65536, 32768};
   const logic [3:0] vtab[8] = '{4'd5, 4'd10, 4'd7, 4'd6, 4'd8, 4'd6, 4'd3, 4'd12};

   function automatic longint rmul(longint a, longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [31:0] sat(longint v);
      return 32'(clampv(v, -64'sd2147483648, 64'sd2147483647));
   endfunction

   function automatic xform_type transform_of(inst_type it);
      xform_type o;
      longint r, x, y, z, dx, dy, c, s, sw, sh, px, py, l00, l10, l01, l11, al;
      bit flip;
      r = longint'($signed(it.angle)) % 411775;
      flip = 0;
      if (r < 0) r += 411775;
      if (r > 205887) r -= 411775;
      if (r > 102944) begin
         r -= 205887; flip = 1;
      end else if (r < -102944) begin
         r += 205887; flip = 1;
      end
      x = 652032874; y = 0; z = r * 16384;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clampv((x + 8192) >>> 14, -65536, 65536);
      s = clampv((y + 8192) >>> 14, -65536, 65536);
      o.cos_out = 16'(clampv((x + 32768) >>> 16, -16384, 16384));
      o.sin_out = 16'(clampv((y + 32768) >>> 16, -16384, 16384));
      px = longint'($signed(it.pos_x)); py = longint'($signed(it.pos_y));
      sw = longint'($signed(it.width)) >>> 1;
      sh = longint'($signed(it.height)) >>> 1;
      l00 = rmul(sw, c); l10 = rmul(sw, s); l01 = rmul(sh, -s); l11 = rmul(sh, c);
      o.m00 = sat(rmul(par_a, l00) + rmul(par_b, l10));
      o.m10 = sat(rmul(par_c, l00) + rmul(par_d, l10));
      o.m01 = sat(rmul(par_a, l01) + rmul(par_b, l11));
      o.m11 = sat(rmul(par_c, l01) + rmul(par_d, l11));
      o.tx = sat(rmul(par_a, px) + rmul(par_b, py) + par_tx);
      o.ty = sat(rmul(par_c, px) + rmul(par_d, py) + par_ty);
      o.shape_out = it.shape_id[2:0];
      o.vcount = vtab[it.shape_id[2:0]];
      o.color_rgb = {it.red, it.green, it.blue};
      al = longint'(it.alpha_in) * grp_alpha;
      o.alpha_out = 16'((al + 127) / 255);
      o.pad = 1'b0;
      return o;
   endfunction

   function automatic logic [31:0] rnd32();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
         3: return 32'(int'($urandom_range(0, 2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic inst_type rnd_inst();
      inst_type it;
      it.pos_x = rnd32(); it.pos_y = rnd32();
      it.width = rnd32(); it.height = rnd32(); it.angle = rnd32();
      it.shape_id = 8'($urandom); it.red = 16'($urandom);
      it.green = 16'($urandom); it.blue = 16'($urandom);
      it.alpha_in = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
      it.active = ($urandom_range(0, 4) != 0);
      return it;
   endfunction

   // Registers are only touched while the pipeline is empty.
   task automatic write_csr(iat_pkg::csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         iat_pkg::CSR_PARENT_A: par_a = longint'($signed(val));
         iat_pkg::CSR_PARENT_B: par_b = longint'($signed(val));
         iat_pkg::CSR_PARENT_C: par_c = longint'($signed(val));
         iat_pkg::CSR_PARENT_D: par_d = longint'($signed(val));
         iat_pkg::CSR_PARENT_TX: par_tx = longint'($signed(val));
         iat_pkg::CSR_PARENT_TY: par_ty = longint'($signed(val));
         iat_pkg::CSR_GROUP_ALPHA: grp_alpha = longint'(val[7:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_insts.size() == 0 && !req_tvalid && expected_xforms.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("instance_affine_transform regression: fail");
         $finish;
      end
   end

   // driver: advance on accept, insert random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_insts.size() != 0 && $urandom_range(0, 3) != 0 ||
                pending_insts.size() != 0 && stall_burst) begin
               inst_type it;
               it = pending_insts.pop_front();
               if (it.active) expected_xforms.push_back(transform_of(it));
               req_tdata <= it[231:0];
               req_tuser <= it.active;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            xform_type got, want;
            got = rsp_tdata;
            if (expected_xforms.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp word, exp none got %h", $time, got);
            end else begin
               want = expected_xforms.pop_front();
               if (got.m00 !== want.m00) begin errors++;
                  $display("%0t m00 exp %h got %h", $time, want.m00, got.m00); end
               if (got.m10 !== want.m10) begin errors++;
                  $display("%0t m10 exp %h got %h", $time, want.m10, got.m10); end
               if (got.m01 !== want.m01) begin errors++;
                  $display("%0t m01 exp %h got %h", $time, want.m01, got.m01); end
               if (got.m11 !== want.m11) begin errors++;
                  $display("%0t m11 exp %h got %h", $time, want.m11, got.m11); end
               if (got.tx !== want.tx) begin errors++;
                  $display("%0t tx exp %h got %h", $time, want.tx, got.tx); end
               if (got.ty !== want.ty) begin errors++;
                  $display("%0t ty exp %h got %h", $time, want.ty, got.ty); end
               if (got.cos_out !== want.cos_out) begin errors++;
                  $display("%0t cos exp %h got %h", $time, want.cos_out, got.cos_out); end
               if (got.sin_out !== want.sin_out) begin errors++;
                  $display("%0t sin exp %h got %h", $time, want.sin_out, got.sin_out); end
               if (got.shape_out !== want.shape_out) begin errors++;
                  $display("%0t shape exp %h got %h", $time, want.shape_out,
                           got.shape_out); end
               if (got.vcount !== want.vcount) begin errors++;
                  $display("%0t vcount exp %h got %h", $time, want.vcount, got.vcount); end
               if (got.color_rgb !== want.color_rgb) begin errors++;
                  $display("%0t color exp %h got %h", $time, want.color_rgb,
                           got.color_rgb); end
               if (got.alpha_out !== want.alpha_out) begin errors++;
                  $display("%0t alpha exp %h got %h", $time, want.alpha_out,
                           got.alpha_out); end
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else if (stall_burst) begin
            hold_off <= 300;
            stall_burst <= 1'b0;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            hold_off <= $urandom_range(10, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      inst_type it;
      par_a = 65536; par_b = 0; par_c = 0; par_d = 65536;
      par_tx = 0; par_ty = 0; grp_alpha = 255;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, angle wraps, shapes, inactive, mirrored size
      for (int k = 0; k < 20; k++) begin
         it = '0;
         it.active = 1'b1;
         it.shape_id = 8'(k * 37);
         it.width = (k % 3 == 0) ? 32'h8000_0000 : (k % 3 == 1) ? 32'h7fff_ffff : 32'hfffe_0000;
         it.height = (k % 2) ? 32'h8000_0000 : 32'h0002_0000;
         it.pos_x = (k % 2) ? 32'h7fff_ffff : 32'h8000_0000;
         it.pos_y = (k % 4 < 2) ? 32'h8000_0000 : 32'h7fff_ffff;
         case (k % 8)
            0: it.angle = 32'd0;
            1: it.angle = 32'd102944;
            2: it.angle = 32'd205887;
            3: it.angle = -32'sd205887;
            4: it.angle = 32'd411775;
            5: it.angle = 32'h8000_0000;
            6: it.angle = 32'h7fff_ffff;
            default: it.angle = 32'd102945;
         endcase
         it.red = (k % 2) ? 16'hffff : 16'h0; it.green = ~it.red; it.blue = 16'h5a5a;
         it.alpha_in = (k % 2) ? 16'hffff : 16'h0;
         if (k == 5 || k == 13) it.active = 1'b0;
         pending_insts.push_back(it);
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(iat_pkg::CSR_GROUP_ALPHA, 32'd0);
            end
            1: begin
               write_csr(iat_pkg::CSR_PARENT_A, 32'h7fff_ffff);
               write_csr(iat_pkg::CSR_PARENT_B, 32'h8000_0000);
               write_csr(iat_pkg::CSR_PARENT_C, 32'h8000_0000);
               write_csr(iat_pkg::CSR_PARENT_D, 32'h7fff_ffff);
               write_csr(iat_pkg::CSR_PARENT_TX, 32'h7fff_ffff);
               write_csr(iat_pkg::CSR_PARENT_TY, 32'h8000_0000);
               write_csr(iat_pkg::CSR_GROUP_ALPHA, 32'hffff_ff80);
            end
            default: begin
               write_csr(iat_pkg::CSR_PARENT_A,
                         ($urandom_range(0, 1)) ? rnd32() : 32'h0001_0000);
               write_csr(iat_pkg::CSR_PARENT_B, rnd32());
               write_csr(iat_pkg::CSR_PARENT_C, rnd32());
               write_csr(iat_pkg::CSR_PARENT_D, rnd32());
               write_csr(iat_pkg::CSR_PARENT_TX, rnd32());
               write_csr(iat_pkg::CSR_PARENT_TY, rnd32());
               write_csr(iat_pkg::CSR_GROUP_ALPHA, (phase == 5) ? 32'd255 : $urandom);
            end
         endcase
         for (int n = 0; n < 310; n++) pending_insts.push_back(rnd_inst());
         // long receiver hold while the sender keeps offering words
         if (phase == 2) stall_burst = 1'b1;
         drain();
      end

      if (errors == 0) begin
         $display("instance_affine_transform regression: pass");
      end else begin
         $display("instance_affine_transform regression: fail");
      end
      $finish;
   end
endmodule
